### rtl/lss_pkg.sv
// shared types and constants of the latency sample statistics block
package lss_pkg;

    localparam int MAX_SAMPLES_DEF = 64;
    localparam int US_W            = 28;
    localparam int ENTRY_W         = US_W + 1;
    localparam int LIMIT_W         = 12;
    localparam int KEPT_W          = 7;
    localparam int TOTAL_W         = 34;
    localparam int SQ_W            = 62;
    localparam int FRAC_BITS       = 8;
    localparam logic [19:0] US_PER_SECOND = 20'd1000000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd512;

    typedef struct packed {
        logic [7:0]  sample_seconds;
        logic [19:0] sample_micro;
        logic        sample_valid;
        logic        last;
    } lss_in_t;

    typedef struct packed {
        logic [US_W-1:0]   min_us;
        logic [US_W-1:0]   max_us;
        logic [US_W-1:0]   average_us;
        logic [US_W-1:0]   stddev_us;
        logic [US_W-1:0]   filtered_average_us;
        logic [KEPT_W-1:0] kept_count;
    } lss_out_t;

    typedef enum logic [7:0] {
        ST_LOAD  = 8'b0000_0001,
        ST_AVG   = 8'b0000_0010,
        ST_SQ    = 8'b0000_0100,
        ST_SQDIV = 8'b0000_1000,
        ST_ROOT  = 8'b0001_0000,
        ST_FILT  = 8'b0010_0000,
        ST_FDIV  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } lss_state_t;

endpackage

### rtl/lss_store.sv
// sample memory, one write and one registered read per cycle
module lss_store #(
    parameter int DEPTH = lss_pkg::MAX_SAMPLES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [lss_pkg::ENTRY_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [lss_pkg::ENTRY_W-1:0] rd_data
);
    import lss_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lss_div.sv
// restoring divider, one quotient bit per cycle
module lss_div #(
    parameter int NW = lss_pkg::SQ_W,
    parameter int DW = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    import lss_pkg::*;

    localparam int SW = $clog2(NW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;
    logic [DW:0]   trial;
    logic          qbit;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, num_reg[NW-1]};
        qbit      = trial >= {1'b0, div_reg};
        if (start) begin
            busy_next = 1'b1;
            step_next = SW'(NW - 1);
            num_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = qbit ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
            num_next = {num_reg[NW-2:0], qbit};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

### rtl/lss_sqrt.sv
// floor square root, one root bit per cycle
module lss_sqrt #(
    parameter int W = lss_pkg::SQ_W
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [W-1:0]    radicand,
    output logic            done,
    output logic [W/2-1:0]  root
);
    import lss_pkg::*;

    localparam int RW = W / 2;
    localparam int SW = $clog2(RW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [W-1:0]  rad_reg, rad_next;
    logic [RW:0]   rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rem_sh    = {rem_reg[RW-1:0], rad_reg[W-1:W-2]};
        trial     = {root_reg, 2'b01};
        if (start) begin
            busy_next = 1'b1;
            step_next = SW'(RW - 1);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = {rad_reg[W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = (RW+1)'(rem_sh - trial);
                root_next = {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[RW:0];
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/latency_sample_statistics.sv
// Latency sample statistics: samples are taken one per cycle while a set loads and are
// kept in a sample memory as whole microseconds; a sample marked last, or the
// MAX_SAMPLES-th one, closes the set. Closing then runs one serial divider for up to
// three divisions, a serial square root and up to two walks over the memory (the
// filter walk is skipped when the deviation is zero, the last division also when no
// sample is kept); no sample is taken during closing. The finished result sits in an
// output register, so the next set may load while it waits.
module latency_sample_statistics #(
    parameter int MAX_SAMPLES = lss_pkg::MAX_SAMPLES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lss_pkg::lss_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lss_pkg::lss_out_t           m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lss_pkg::LIMIT_W-1:0] cfg_data
);
    import lss_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int LW = US_W + LIMIT_W;

    lss_state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_cfg_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [TOTAL_W-1:0] vtotal_reg, vtotal_next;
    logic [US_W-1:0]    min_reg, min_next;
    logic [US_W-1:0]    max_reg, max_next;
    logic               any_reg, any_next;
    logic [SQ_W-1:0]    sqtotal_reg, sqtotal_next;
    logic [TOTAL_W-1:0] ktotal_reg, ktotal_next;
    logic [CW-1:0]      kept_reg, kept_next;
    logic [CW-1:0]      nvalid_reg, nvalid_next;
    logic [US_W-1:0]    avg_reg, avg_next;
    logic [US_W-1:0]    sd_reg, sd_next;
    logic [US_W-1:0]    filt_reg, filt_next;
    logic [LW-1:0]      lim_reg, lim_next;
    logic               go_reg, go_next;

    // walk pipeline
    logic [CW-1:0]      idx_reg, idx_next;
    logic               p1_reg, p2_reg, p3_reg;
    logic               issuing;
    logic [US_W-1:0]    x2_reg;
    logic               v2_reg, v3_reg;
    logic [US_W-1:0]    d2_reg;
    logic [2*US_W-1:0]  sq3_reg;
    logic [US_W-1:0]    rd_x;
    logic [US_W-1:0]    rd_d;

    logic               m_valid_reg, m_valid_next;
    lss_out_t           m_data_reg, m_data_next;

    logic [US_W-1:0]    sample_us;
    logic               s_fire;
    logic [ENTRY_W-1:0] rd_data;

    logic               div_start;
    logic [SQ_W-1:0]    div_dividend;
    logic [CW-1:0]      div_divisor;
    logic               div_done;
    logic [SQ_W-1:0]    div_q;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [SQ_W/2-1:0]  sqrt_root;
    logic               walk_end;

    assign sample_us = US_W'(s_data.sample_seconds) * US_W'(US_PER_SECOND)
                     + US_W'(s_data.sample_micro);
    assign s_ready   = (state_reg == ST_LOAD);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign issuing   = (state_reg == ST_SQ || state_reg == ST_FILT) && (idx_reg < cnt_reg);
    assign walk_end  = (idx_reg == cnt_reg) && !p1_reg && !p2_reg && !p3_reg;
    assign rd_x      = rd_data[US_W-1:0];
    assign rd_d      = (rd_x >= avg_reg) ? rd_x - avg_reg : avg_reg - rd_x;

    lss_store #(.DEPTH(MAX_SAMPLES), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (s_fire),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data ({s_data.sample_valid, sample_us}),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        div_dividend = SQ_W'(vtotal_reg);
        div_divisor  = cnt_reg;
        if (state_reg == ST_SQDIV) begin
            div_dividend = sqtotal_reg;
        end else if (state_reg == ST_FDIV) begin
            div_dividend = SQ_W'(ktotal_reg);
            div_divisor  = kept_reg;
        end
    end

    assign div_start  = go_reg && (state_reg == ST_AVG || state_reg == ST_SQDIV
                                   || state_reg == ST_FDIV);
    assign sqrt_start = go_reg && (state_reg == ST_ROOT);

    lss_div #(.NW(SQ_W), .DW(CW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    lss_sqrt #(.W(SQ_W)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_q),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        vtotal_next  = vtotal_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        any_next     = any_reg;
        sqtotal_next = sqtotal_reg;
        ktotal_next  = ktotal_reg;
        kept_next    = kept_reg;
        nvalid_next  = nvalid_reg;
        avg_next     = avg_reg;
        sd_next      = sd_reg;
        filt_next    = filt_reg;
        lim_next     = lim_reg;
        go_next      = 1'b0;
        idx_next     = issuing ? idx_reg + 1'b1 : idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (s_data.sample_valid) begin
                        vtotal_next = vtotal_reg + TOTAL_W'(sample_us);
                        if (!any_reg || sample_us < min_reg) min_next = sample_us;
                        if (!any_reg || sample_us > max_reg) max_next = sample_us;
                        any_next = 1'b1;
                    end
                    if (s_data.last || cnt_next == CW'(MAX_SAMPLES)) begin
                        state_next = ST_AVG;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_AVG: begin
                if (div_done) begin
                    avg_next     = div_q[US_W-1:0];
                    sqtotal_next = '0;
                    nvalid_next  = '0;
                    idx_next     = '0;
                    state_next   = ST_SQ;
                end
            end
            ST_SQ: begin
                if (p3_reg && v3_reg) begin
                    sqtotal_next = sqtotal_reg + SQ_W'(sq3_reg);
                    nvalid_next  = nvalid_reg + 1'b1;
                end
                if (walk_end) begin
                    state_next = ST_SQDIV;
                    go_next    = 1'b1;
                end
            end
            ST_SQDIV: begin
                if (div_done) begin
                    state_next = ST_ROOT;
                    go_next    = 1'b1;
                end
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    sd_next  = sqrt_root[US_W-1:0];
                    lim_next = sqrt_root[US_W-1:0] * limit_cfg_reg;
                    if (sqrt_root == '0) begin
                        filt_next  = avg_reg;
                        kept_next  = nvalid_reg;
                        state_next = ST_DONE;
                    end else begin
                        ktotal_next = '0;
                        kept_next   = '0;
                        idx_next    = '0;
                        state_next  = ST_FILT;
                    end
                end
            end
            ST_FILT: begin
                // deviation scaled by 256 against stddev times limit
                if (p2_reg && v2_reg && LW'({d2_reg, {FRAC_BITS{1'b0}}}) <= lim_reg) begin
                    ktotal_next = ktotal_reg + TOTAL_W'(x2_reg);
                    kept_next   = kept_reg + 1'b1;
                end
                if (walk_end) begin
                    if (kept_reg == '0) begin
                        filt_next  = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_FDIV;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_FDIV: begin
                if (div_done) begin
                    filt_next  = div_q[US_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                     = 1'b1;
                    m_data_next.min_us               = any_reg ? min_reg : '0;
                    m_data_next.max_us               = any_reg ? max_reg : '0;
                    m_data_next.average_us           = avg_reg;
                    m_data_next.stddev_us            = sd_reg;
                    m_data_next.filtered_average_us  = filt_reg;
                    m_data_next.kept_count           = KEPT_W'(kept_reg);
                    cnt_next    = '0;
                    vtotal_next = '0;
                    min_next    = '0;
                    max_next    = '0;
                    any_next    = 1'b0;
                    state_next  = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            limit_cfg_reg <= LIMIT_RESET;
            cnt_reg       <= '0;
            vtotal_reg    <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            any_reg       <= 1'b0;
            go_reg        <= 1'b0;
            idx_reg       <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            p3_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_valid) begin
                limit_cfg_reg <= cfg_data;
            end
            cnt_reg     <= cnt_next;
            vtotal_reg  <= vtotal_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            any_reg     <= any_next;
            go_reg      <= go_next;
            idx_reg     <= idx_next;
            p1_reg      <= issuing;
            p2_reg      <= p1_reg;
            p3_reg      <= p2_reg;
            m_valid_reg <= m_valid_next;
        end
        sqtotal_reg <= sqtotal_next;
        ktotal_reg  <= ktotal_next;
        kept_reg    <= kept_next;
        nvalid_reg  <= nvalid_next;
        avg_reg     <= avg_next;
        sd_reg      <= sd_next;
        filt_reg    <= filt_next;
        lim_reg     <= lim_next;
        x2_reg      <= rd_x;
        v2_reg      <= rd_data[US_W];
        d2_reg      <= rd_d;
        v3_reg      <= v2_reg;
        sq3_reg     <= d2_reg * d2_reg;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
